// ----- hw/rtl/lte_codebook_precoder_unit_macros.svh -----
// assertion helpers for the codebook precoder
`ifndef LTE_CODEBOOK_PRECODER_UNIT_MACROS_SVH
`define LTE_CODEBOOK_PRECODER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define LCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcp: implication check failed");

// next-cycle implication, held off during reset
`define LCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcp: next-cycle check failed");

`endif

// ----- hw/rtl/lcp_pkg.sv -----
`default_nettype none

package lcp_pkg;

  // sample and arithmetic widths
  localparam int SAMPLE_WIDTH      = 16;
  localparam int FOUR_PORT_ENTRIES = 16;
  localparam int COEF_WIDTH        = 17;
  localparam int COEF_FRAC         = 15;
  localparam int PROD_WIDTH        = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH         = PROD_WIDTH + 2;
  localparam int CB_WIDTH          = $clog2(FOUR_PORT_ENTRIES);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;

  typedef struct packed {
    coef_t re;
    coef_t im;
  } cplx_coef_t;

  // input word: one layer vector
  typedef struct packed {
    sample_t layer0_re;
    sample_t layer0_im;
    sample_t layer1_re;
    sample_t layer1_im;
    logic    last_in;
  } in_word_t;

  // output word: four antenna ports
  typedef struct packed {
    sample_t port0_re;
    sample_t port0_im;
    sample_t port1_re;
    sample_t port1_im;
    sample_t port2_re;
    sample_t port2_im;
    sample_t port3_re;
    sample_t port3_im;
    logic    config_error;
    logic    last_out;
  } out_word_t;

  // configuration register indexes
  localparam logic [2:0] CFG_SCHEME   = 3'd0;
  localparam logic [2:0] CFG_CDD      = 3'd1;
  localparam logic [2:0] CFG_PORTS    = 3'd2;
  localparam logic [2:0] CFG_LAYERS   = 3'd3;
  localparam logic [2:0] CFG_CODEBOOK = 3'd4;

  // coefficients in Q.15
  localparam coef_t C_UNIT = 17'sd32768;
  localparam coef_t C_RT   = 17'sd23170;
  localparam coef_t C_HALF = 17'sd16384;
  localparam coef_t C_Q    = 17'sd11585;

  // phase codes of u elements 1..3, packed {u1, u2, u3}, u = exp(j*pi*k/4)
  localparam logic [8:0] U_PHASE [FOUR_PORT_ENTRIES] = '{
    {3'd4, 3'd4, 3'd4}, {3'd6, 3'd0, 3'd2}, {3'd0, 3'd4, 3'd0}, {3'd2, 3'd0, 3'd6},
    {3'd5, 3'd6, 3'd7}, {3'd7, 3'd2, 3'd5}, {3'd1, 3'd6, 3'd3}, {3'd3, 3'd2, 3'd1},
    {3'd4, 3'd0, 3'd0}, {3'd6, 3'd4, 3'd6}, {3'd0, 3'd0, 3'd4}, {3'd2, 3'd4, 3'd2},
    {3'd4, 3'd4, 3'd0}, {3'd4, 3'd0, 3'd4}, {3'd0, 3'd4, 3'd4}, {3'd0, 3'd0, 3'd0}
  };

  // 0.5 * exp(j*pi*k/4)
  function automatic cplx_coef_t half_phase(input logic [2:0] k);
    cplx_coef_t c;
    case (k)
      3'd0:    c = '{re:  C_HALF, im:  '0};
      3'd1:    c = '{re:  C_Q,    im:  C_Q};
      3'd2:    c = '{re:  '0,     im:  C_HALF};
      3'd3:    c = '{re: -C_Q,    im:  C_Q};
      3'd4:    c = '{re: -C_HALF, im:  '0};
      3'd5:    c = '{re: -C_Q,    im: -C_Q};
      3'd6:    c = '{re:  '0,     im: -C_HALF};
      default: c = '{re:  C_Q,    im: -C_Q};
    endcase
    return c;
  endfunction

  // round half up, drop the fraction, saturate to the sample range
  function automatic sample_t round_sat(input acc_t a);
    acc_t                           t;
    logic [ACC_WIDTH-COEF_FRAC-1:0] r;
    sample_t                        s;
    t = a + acc_t'(1 <<< (COEF_FRAC - 1));
    r = t[ACC_WIDTH-1:COEF_FRAC];
    if (&r[ACC_WIDTH-COEF_FRAC-1:SAMPLE_WIDTH-1] || ~|r[ACC_WIDTH-COEF_FRAC-1:SAMPLE_WIDTH-1]) begin
      s = r[SAMPLE_WIDTH-1:0];
    end else if (r[ACC_WIDTH-COEF_FRAC-1]) begin
      s = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      s = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lte_codebook_precoder_unit.sv -----
// done_o: a start passes the stage 1, 2 and 3 valid registers, then out_valid_q, which drives done_o
// throughput: one word per cycle; busy_o never rises, since the receiver cannot stall
// pipeline: coefficient decode, complex multiply, layer sum, round and saturate
// reset: config registers return to spatial multiplexing, two ports, one layer, index 0,
// and all stage valid bits clear; payload registers are not reset
`default_nettype none

module lte_codebook_precoder_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [2:0]           cfg_idx_i,
  input  wire  [3:0]           cfg_wdata_i,
  input  wire                  start_i,
  input  lcp_pkg::in_word_t    in_i,
  output logic                 busy_o,
  output logic                 done_o,
  output lcp_pkg::out_word_t   out_o
);

  localparam int NP = 4;
  localparam int NL = 2;

  // configuration registers
  logic       scheme_q, cdd_q;
  logic [2:0] ports_q;
  logic [1:0] layers_q;
  logic [lcp_pkg::CB_WIDTH-1:0] cb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= 1'b1;
      cdd_q    <= 1'b0;
      ports_q  <= 3'd2;
      layers_q <= 2'd1;
      cb_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcp_pkg::CFG_SCHEME:   scheme_q <= cfg_wdata_i[0];
        lcp_pkg::CFG_CDD:      cdd_q    <= cfg_wdata_i[0];
        lcp_pkg::CFG_PORTS:    ports_q  <= cfg_wdata_i[2:0];
        lcp_pkg::CFG_LAYERS:   layers_q <= cfg_wdata_i[1:0];
        lcp_pkg::CFG_CODEBOOK: cb_q     <= cfg_wdata_i[lcp_pkg::CB_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // precoding matrix decode from the config registers
  lcp_pkg::coef_t w_re [NP][NL];
  lcp_pkg::coef_t w_im [NP][NL];
  logic           cfg_err;

  always_comb begin
    logic [8:0]          ph;
    logic [2:0]          k;
    lcp_pkg::cplx_coef_t hc;
    ph      = lcp_pkg::U_PHASE[cb_q];
    k       = '0;
    hc      = '0;
    cfg_err = 1'b0;
    for (int p = 0; p < NP; p++) begin
      for (int l = 0; l < NL; l++) begin
        w_re[p][l] = '0;
        w_im[p][l] = '0;
      end
    end
    if (!scheme_q) begin
      if (ports_q != 3'd1) cfg_err = 1'b1;
      else w_re[0][0] = lcp_pkg::C_UNIT;
    end else if (cdd_q) begin
      cfg_err = 1'b1;
    end else if (ports_q == 3'd2) begin
      if (layers_q == 2'd1 && cb_q <= 4'd3) begin
        w_re[0][0] = lcp_pkg::C_RT;
        case (cb_q[1:0])
          2'd0:    w_re[1][0] =  lcp_pkg::C_RT;
          2'd1:    w_re[1][0] = -lcp_pkg::C_RT;
          2'd2:    w_im[1][0] =  lcp_pkg::C_RT;
          default: w_im[1][0] = -lcp_pkg::C_RT;
        endcase
      end else if (layers_q == 2'd2 && cb_q <= 4'd2) begin
        if (cb_q == 4'd0) begin
          w_re[0][0] = lcp_pkg::C_RT;
          w_re[1][1] = lcp_pkg::C_RT;
        end else begin
          w_re[0][0] = lcp_pkg::C_HALF;
          w_re[0][1] = lcp_pkg::C_HALF;
          if (cb_q == 4'd1) begin
            w_re[1][0] =  lcp_pkg::C_HALF;
            w_re[1][1] = -lcp_pkg::C_HALF;
          end else begin
            w_im[1][0] =  lcp_pkg::C_HALF;
            w_im[1][1] = -lcp_pkg::C_HALF;
          end
        end
      end else begin
        cfg_err = 1'b1;
      end
    end else if (ports_q == 3'd4) begin
      if (layers_q != 2'd1) begin
        cfg_err = 1'b1;
      end else begin
        // first column of the householder matrix: 1/2, then -u_p/2
        w_re[0][0] = lcp_pkg::C_HALF;
        for (int p = 1; p < NP; p++) begin
          k          = ph[3*(NP-1-p) +: 3] + 3'd4;
          hc         = lcp_pkg::half_phase(k);
          w_re[p][0] = hc.re;
          w_im[p][0] = hc.im;
        end
      end
    end else begin
      cfg_err = 1'b1;
    end
  end

  // stage 1: samples and coefficients
  logic              s1_valid_q;
  logic              s1_err_q, s1_last_q;
  lcp_pkg::sample_t  x_re_q [NL];
  lcp_pkg::sample_t  x_im_q [NL];
  lcp_pkg::coef_t    w_re_q [NP][NL];
  lcp_pkg::coef_t    w_im_q [NP][NL];

  always_ff @(posedge clk_i) begin
    x_re_q[0] <= in_i.layer0_re;
    x_im_q[0] <= in_i.layer0_im;
    x_re_q[1] <= in_i.layer1_re;
    x_im_q[1] <= in_i.layer1_im;
    w_re_q    <= w_re;
    w_im_q    <= w_im;
    s1_err_q  <= cfg_err;
    s1_last_q <= in_i.last_in;
  end

  // stage 2: partial products
  logic         s2_valid_q;
  logic         s2_err_q, s2_last_q;
  lcp_pkg::prod_t prr_d [NP][NL], pii_d [NP][NL], pri_d [NP][NL], pir_d [NP][NL];
  lcp_pkg::prod_t prr_q [NP][NL], pii_q [NP][NL], pri_q [NP][NL], pir_q [NP][NL];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int l = 0; l < NL; l++) begin
        prr_d[p][l] = w_re_q[p][l] * x_re_q[l];
        pii_d[p][l] = w_im_q[p][l] * x_im_q[l];
        pri_d[p][l] = w_re_q[p][l] * x_im_q[l];
        pir_d[p][l] = w_im_q[p][l] * x_re_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prr_q     <= prr_d;
    pii_q     <= pii_d;
    pri_q     <= pri_d;
    pir_q     <= pir_d;
    s2_err_q  <= s1_err_q;
    s2_last_q <= s1_last_q;
  end

  // stage 3: sum over layers
  logic          s3_valid_q;
  logic          s3_err_q, s3_last_q;
  lcp_pkg::acc_t acc_re_d [NP], acc_im_d [NP];
  lcp_pkg::acc_t acc_re_q [NP], acc_im_q [NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      acc_re_d[p] = lcp_pkg::acc_t'(prr_q[p][0]) - lcp_pkg::acc_t'(pii_q[p][0])
                  + lcp_pkg::acc_t'(prr_q[p][1]) - lcp_pkg::acc_t'(pii_q[p][1]);
      acc_im_d[p] = lcp_pkg::acc_t'(pri_q[p][0]) + lcp_pkg::acc_t'(pir_q[p][0])
                  + lcp_pkg::acc_t'(pri_q[p][1]) + lcp_pkg::acc_t'(pir_q[p][1]);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q  <= acc_re_d;
    acc_im_q  <= acc_im_d;
    s3_err_q  <= s2_err_q;
    s3_last_q <= s2_last_q;
  end

  // stage 4: round, saturate and register the output word
  logic               out_valid_q;
  lcp_pkg::out_word_t out_d, out_q;

  always_comb begin
    out_d.port0_re     = lcp_pkg::round_sat(acc_re_q[0]);
    out_d.port0_im     = lcp_pkg::round_sat(acc_im_q[0]);
    out_d.port1_re     = lcp_pkg::round_sat(acc_re_q[1]);
    out_d.port1_im     = lcp_pkg::round_sat(acc_im_q[1]);
    out_d.port2_re     = lcp_pkg::round_sat(acc_re_q[2]);
    out_d.port2_im     = lcp_pkg::round_sat(acc_im_q[2]);
    out_d.port3_re     = lcp_pkg::round_sat(acc_re_q[3]);
    out_d.port3_im     = lcp_pkg::round_sat(acc_im_q[3]);
    out_d.config_error = s3_err_q;
    out_d.last_out     = s3_last_q;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // valid bits through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start_i && !busy_o;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // the pipeline takes a word every cycle
  assign busy_o = 1'b0;
  assign done_o = out_valid_q;
  assign out_o  = out_q;

  // checks
`include "lte_codebook_precoder_unit_macros.svh"

  `LCP_ASSERT_IMP(a_fixed_latency, start_i && !busy_o, ##4 done_o)
  `LCP_ASSERT_IMP(a_last_follows, done_o, out_o.last_out == $past(in_i.last_in, 4))
  `LCP_ASSERT_IMP(a_error_zeroes, done_o && out_o.config_error,
    out_o.port0_re == '0 && out_o.port0_im == '0 && out_o.port1_re == '0 &&
    out_o.port1_im == '0 && out_o.port2_re == '0 && out_o.port2_im == '0 &&
    out_o.port3_re == '0 && out_o.port3_im == '0)
  `LCP_ASSERT_NXT(a_valid_chain, s2_valid_q, s3_valid_q)

endmodule

`default_nettype wire
